@@ hw/rtl/bfbp_pkg.sv @@
package bfbp_pkg;

	localparam int POOL_DEPTH_DEF  = 16;
	localparam int HANDLE_BITS_DEF = 16;
	localparam int SIZE_W          = 32;
	localparam int HANDLE_W        = 16;

	localparam logic OP_RETURN  = 1'b0;
	localparam logic OP_ACQUIRE = 1'b1;

	typedef enum logic [1:0] {
		ST_GIVEN   = 2'd0,
		ST_MISS    = 2'd1,
		ST_STORED  = 2'd2,
		ST_DROPPED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_SCAN_END,
		S_DECIDE,
		S_SHIFT,
		S_SHIFT_END,
		S_DONE
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic    take_in;
		logic    wr_append;
		logic    occ_inc;
		logic    occ_dec;
		logic    idx_clear;
		logic    idx_load_best;
		logic    rd_en;
		logic    shift;
		logic    set_status;
		status_t status;
		logic    load_out;
	} bfbp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic op_acq;
		logic pool_empty;
		logic pool_full;
		logic idx_last;
		logic found;
		logic best_last;
		logic out_free;
	} bfbp_sts_t;

endpackage

@@ hw/rtl/bfbp_req_if.sv @@
interface bfbp_req_if import bfbp_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                opcode;
	logic [SIZE_W-1:0]   request_size;
	logic [HANDLE_W-1:0] return_handle;

	modport source (output valid, output opcode, output request_size, output return_handle,
		input ready);
	modport sink (input valid, input opcode, input request_size, input return_handle,
		output ready);
endinterface

@@ hw/rtl/bfbp_rsp_if.sv @@
interface bfbp_rsp_if import bfbp_pkg::*; ();
	logic                valid;
	logic                ready;
	status_t             status;
	logic [HANDLE_W-1:0] given_handle;
	logic [SIZE_W-1:0]   given_size;

	modport source (output valid, output status, output given_handle, output given_size,
		input ready);
	modport sink (input valid, input status, input given_handle, input given_size,
		output ready);
endinterface

@@ hw/rtl/best_fit_buffer_pool.sv @@
// Best-fit buffer pool: free buffers (handle, byte size) kept in return order.
// req channel: opcode 0 returns a buffer (appended at the tail), opcode 1
// acquires one; the smallest entry with size >= request_size is removed and
// given back, ties to the earliest returned. rsp channel: one result per
// request (given, miss, stored, or dropped when the pool is full).
// One request is worked at a time; req.ready is high only while idle.
// A return, or an acquire on an empty pool, is answered without a scan. An acquire
// scans every entry held, a scan reading one entry per cycle; when the entry taken
// is not the tail, the entries behind it then move down one place to close the
// gap, one entry per cycle.
// The result waits in an output register; a request may be accepted while it
// waits, and its own result is held back until rsp takes the earlier one.
// Reset empties the pool and drops any result not yet taken; the memory itself
// is not cleared, only entries below the fill count are ever read.
module best_fit_buffer_pool import bfbp_pkg::*; #(
	parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	bfbp_req_if.sink   req,
	bfbp_rsp_if.source rsp
);

	bfbp_cmd_t cmd;
	bfbp_sts_t sts;
	logic      in_ready;

	assign req.ready = in_ready;

	bfbp_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	bfbp_dp #(
		.POOL_DEPTH (POOL_DEPTH),
		.HANDLE_BITS(HANDLE_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.opcode       (req.opcode),
		.request_size (req.request_size),
		.return_handle(req.return_handle),
		.cmd          (cmd),
		.sts          (sts),
		.rsp          (rsp)
	);

endmodule

@@ hw/rtl/bfbp_ram.sv @@
module bfbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/bfbp_ctrl.sv @@
module bfbp_ctrl import bfbp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  bfbp_sts_t sts,
	output bfbp_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take_in = 1'b1;
					state_d     = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.set_status = 1'b1;
				if (!sts.op_acq) begin
					if (sts.pool_full) begin
						cmd.status = ST_DROPPED;
					end else begin
						cmd.status    = ST_STORED;
						cmd.wr_append = 1'b1;
						cmd.occ_inc   = 1'b1;
					end
					state_d = S_DONE;
				end else if (sts.pool_empty) begin
					cmd.status = ST_MISS;
					state_d    = S_DONE;
				end else begin
					cmd.set_status = 1'b0;
					cmd.idx_clear  = 1'b1;
					state_d        = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd.rd_en = 1'b1;
				if (sts.idx_last) begin
					state_d = S_SCAN_END;
				end
			end
			S_SCAN_END: begin
				// last compare lands at this edge
				state_d = S_DECIDE;
			end
			S_DECIDE: begin
				cmd.set_status = 1'b1;
				if (!sts.found) begin
					cmd.status = ST_MISS;
					state_d    = S_DONE;
				end else if (sts.best_last) begin
					cmd.status  = ST_GIVEN;
					cmd.occ_dec = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.status        = ST_GIVEN;
					cmd.idx_load_best = 1'b1;
					state_d           = S_SHIFT;
				end
			end
			S_SHIFT: begin
				cmd.rd_en = 1'b1;
				cmd.shift = 1'b1;
				if (sts.idx_last) begin
					state_d = S_SHIFT_END;
				end
			end
			S_SHIFT_END: begin
				cmd.occ_dec = 1'b1;
				state_d     = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

@@ hw/rtl/bfbp_dp.sv @@
module bfbp_dp import bfbp_pkg::*; #(
	parameter int POOL_DEPTH  = POOL_DEPTH_DEF,
	parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                opcode,
	input  logic [SIZE_W-1:0]   request_size,
	input  logic [HANDLE_W-1:0] return_handle,
	input  bfbp_cmd_t           cmd,
	output bfbp_sts_t           sts,
	bfbp_rsp_if.source          rsp
);

	localparam int IDX_W = $clog2(POOL_DEPTH);
	localparam int OCC_W = $clog2(POOL_DEPTH + 1);
	localparam int ENT_W = SIZE_W + HANDLE_BITS;

	logic                   op_q;
	logic [SIZE_W-1:0]      size_q;
	logic [HANDLE_BITS-1:0] handle_q;
	logic [OCC_W-1:0]       occ_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   rd_vld_s1;
	logic                   rd_shift_s1;
	logic [IDX_W-1:0]       rd_idx_s1;
	logic                   found_q;
	logic [IDX_W-1:0]       best_q;
	logic [SIZE_W-1:0]      best_size_q;
	logic [HANDLE_BITS-1:0] best_handle_q;
	status_t                res_status_q;
	logic                   out_valid_q;
	status_t                out_status_q;
	logic [HANDLE_W-1:0]    out_handle_q;
	logic [SIZE_W-1:0]      out_size_q;

	logic                   ram_we;
	logic [IDX_W-1:0]       ram_waddr;
	logic [ENT_W-1:0]       ram_wdata;
	logic [ENT_W-1:0]       ram_rdata;
	logic [SIZE_W-1:0]      rd_size;
	logic [HANDLE_BITS-1:0] rd_handle;
	logic                   fits;
	logic                   better;
	logic                   take_entry;
	logic                   out_free;
	logic [OCC_W-1:0]       last_idx;

	assign rd_size    = ram_rdata[HANDLE_BITS +: SIZE_W];
	assign rd_handle  = ram_rdata[HANDLE_BITS-1:0];
	assign fits       = rd_size >= size_q;
	assign better     = !found_q || (rd_size < best_size_q);
	assign take_entry = rd_vld_s1 && !rd_shift_s1 && fits && better;
	assign out_free   = !out_valid_q || rsp.ready;
	assign last_idx   = occ_q - OCC_W'(1);

	// append at the tail, or move the entry read last cycle down by one
	assign ram_we    = cmd.wr_append || (rd_vld_s1 && rd_shift_s1);
	assign ram_waddr = cmd.wr_append ? occ_q[IDX_W-1:0] : rd_idx_s1 - IDX_W'(1);
	assign ram_wdata = cmd.wr_append ? {size_q, handle_q} : ram_rdata;

	bfbp_ram #(
		.WIDTH(ENT_W),
		.DEPTH(POOL_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	always_comb begin
		sts.op_acq     = op_q == OP_ACQUIRE;
		sts.pool_empty = occ_q == '0;
		sts.pool_full  = occ_q == OCC_W'(POOL_DEPTH);
		sts.idx_last   = OCC_W'(idx_q) == last_idx;
		sts.found      = found_q;
		sts.best_last  = OCC_W'(best_q) == last_idx;
		sts.out_free   = out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			rd_vld_s1   <= 1'b0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.occ_inc) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (cmd.occ_dec) begin
				occ_q <= occ_q - OCC_W'(1);
			end
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.take_in) begin
				found_q <= 1'b0;
			end else if (take_entry) begin
				found_q <= 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q     <= opcode;
			size_q   <= request_size;
			handle_q <= HANDLE_BITS'(return_handle);
		end
		if (cmd.idx_clear) begin
			idx_q <= '0;
		end else if (cmd.idx_load_best) begin
			idx_q <= best_q + IDX_W'(1);
		end else if (cmd.rd_en) begin
			idx_q <= idx_q + IDX_W'(1);
		end
		rd_shift_s1 <= cmd.shift;
		rd_idx_s1   <= idx_q;
		if (take_entry) begin
			best_q        <= rd_idx_s1;
			best_size_q   <= rd_size;
			best_handle_q <= rd_handle;
		end
		if (cmd.set_status) begin
			res_status_q <= cmd.status;
		end
		if (cmd.load_out) begin
			out_status_q <= res_status_q;
			if (res_status_q == ST_GIVEN) begin
				out_handle_q <= HANDLE_W'(best_handle_q);
				out_size_q   <= best_size_q;
			end else begin
				out_handle_q <= '0;
				out_size_q   <= '0;
			end
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.given_handle = out_handle_q;
	assign rsp.given_size   = out_size_q;

`ifndef SYNTHESIS
	a_occ_range: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(POOL_DEPTH))
		else $error("occupancy above pool depth");

	a_append_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_append |-> occ_q < OCC_W'(POOL_DEPTH))
		else $error("append into a full pool");

	a_read_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> OCC_W'(rd_idx_s1) < occ_q)
		else $error("read beyond the valid entries");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> out_free)
		else $error("result register overwritten");

	a_dec_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.occ_dec |=> occ_q == $past(occ_q) - OCC_W'(1))
		else $error("occupancy did not drop by one");
`endif

endmodule

@@ tb/sv/best_fit_buffer_pool_tb.sv @@
`timescale 1ns / 1ps

module best_fit_buffer_pool_tb import bfbp_pkg::*; ();

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int RANDOM_ITEMS = 1825;
	localparam int PHASE_LEN    = 60;
	localparam int DRAIN_CYCLES = 2 * POOL_DEPTH_DEF + 16;
	localparam logic [HANDLE_W-1:0] HANDLE_KEEP = (HANDLE_BITS_DEF >= HANDLE_W) ?
		{HANDLE_W{1'b1}} : HANDLE_W'((1 << HANDLE_BITS_DEF) - 1);

	typedef struct packed {
		status_t             status;
		logic [HANDLE_W-1:0] handle;
		logic [SIZE_W-1:0]   size;
	} reply_t;

	typedef struct packed {
		logic                op;
		logic [SIZE_W-1:0]   size;
		logic [HANDLE_W-1:0] handle;
		logic                typed;
		reply_t              reply;
	} request_row_t;

	localparam reply_t NO_REPLY = '{ST_GIVEN, '0, '0};
	localparam reply_t MISS_R   = '{ST_MISS, '0, '0};
	localparam reply_t STORED_R = '{ST_STORED, '0, '0};
	localparam reply_t DROP_R   = '{ST_DROPPED, '0, '0};

	// Known outcomes are typed in; the rest come from the best-fit predictor.
	localparam request_row_t DIRECTED [25] = '{
		'{OP_ACQUIRE, 32'd0,          16'h0000, 1'b1, MISS_R},
		'{OP_RETURN,  32'd0,          16'h0000, 1'b1, STORED_R},
		'{OP_RETURN,  32'hFFFF_FFFF,  16'hFFFF, 1'b1, STORED_R},
		'{OP_ACQUIRE, 32'hFFFF_FFFF,  16'h1234, 1'b1, '{ST_GIVEN, 16'hFFFF, 32'hFFFF_FFFF}},
		'{OP_ACQUIRE, 32'd1,          16'h0000, 1'b1, MISS_R},
		'{OP_ACQUIRE, 32'd0,          16'hFFFF, 1'b1, '{ST_GIVEN, 16'h0000, 32'd0}},
		'{OP_RETURN,  32'd100,        16'hAAAA, 1'b1, STORED_R},
		'{OP_RETURN,  32'd50,         16'h5555, 1'b1, STORED_R},
		'{OP_RETURN,  32'd50,         16'h0001, 1'b1, STORED_R},
		'{OP_RETURN,  32'd300,        16'h8000, 1'b1, STORED_R},
		'{OP_RETURN,  32'd7,          16'h0F0F, 1'b1, STORED_R},
		'{OP_RETURN,  32'd50,         16'hF0F0, 1'b1, STORED_R},
		'{OP_RETURN,  32'd1000,       16'h00FF, 1'b1, STORED_R},
		'{OP_RETURN,  32'd8,          16'hFF00, 1'b1, STORED_R},
		'{OP_RETURN,  32'd9,          16'h3333, 1'b1, STORED_R},
		'{OP_RETURN,  32'd2048,       16'hCCCC, 1'b1, STORED_R},
		'{OP_RETURN,  32'd50,         16'h1111, 1'b1, STORED_R},
		'{OP_RETURN,  32'd12,         16'h2222, 1'b1, STORED_R},
		'{OP_RETURN,  32'd4095,       16'h4444, 1'b1, STORED_R},
		'{OP_RETURN,  32'd65536,      16'h7777, 1'b1, STORED_R},
		'{OP_RETURN,  32'h8000_0000,  16'hEEEE, 1'b1, STORED_R},
		'{OP_RETURN,  32'd1,          16'h9999, 1'b1, STORED_R},
		'{OP_RETURN,  32'd5,          16'hFFFF, 1'b1, DROP_R},
		'{OP_ACQUIRE, 32'd50,         16'h0000, 1'b0, NO_REPLY},
		'{OP_ACQUIRE, 32'd10,         16'h0000, 1'b0, NO_REPLY}
	};

	logic clk;
	logic arst_n;

	bfbp_req_if req_if ();
	bfbp_rsp_if rsp_if ();

	best_fit_buffer_pool dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	logic [SIZE_W-1:0]   pool_size [POOL_DEPTH_DEF];
	logic [HANDLE_W-1:0] pool_handle [POOL_DEPTH_DEF];
	int                  pool_fill;
	reply_t              replies_due [$];
	int                  failures;
	int                  cycles;
	bit                  quiet;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [SIZE_W-1:0] pick_size();
		case ($urandom_range(0, 3))
			0, 1: return SIZE_W'($urandom_range(0, 15));
			2: return SIZE_W'($urandom_range(0, 4096));
			default: return SIZE_W'($urandom);
		endcase
	endfunction

	// Apply one request to the shadow pool and return the reply it earns.
	function automatic reply_t best_fit_apply(input logic op, input logic [SIZE_W-1:0] sz,
			input logic [HANDLE_W-1:0] hd);
		reply_t r;
		int pick;
		r = MISS_R;
		pick = -1;
		if (op == OP_RETURN) begin
			if (pool_fill >= POOL_DEPTH_DEF) begin
				r = DROP_R;
			end else begin
				pool_size[pool_fill] = sz;
				pool_handle[pool_fill] = hd & HANDLE_KEEP;
				pool_fill++;
				r = STORED_R;
			end
		end else begin
			for (int i = 0; i < pool_fill; i++)
				if (pool_size[i] >= sz && (pick < 0 || pool_size[i] < pool_size[pick]))
					pick = i;
			if (pick >= 0) begin
				r = '{ST_GIVEN, pool_handle[pick], pool_size[pick]};
				// close the gap, keeping return order
				for (int i = pick; i + 1 < pool_fill; i++) begin
					pool_size[i] = pool_size[i + 1];
					pool_handle[i] = pool_handle[i + 1];
				end
				pool_fill--;
			end
		end
		return r;
	endfunction

	task automatic push_request(input logic op, input logic [SIZE_W-1:0] sz,
			input logic [HANDLE_W-1:0] hd, input logic typed, input reply_t typed_reply);
		int gap;
		reply_t predicted;
		gap = idle_span();
		if (gap > 0) begin
			req_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_if.valid         <= 1'b1;
		req_if.opcode        <= op;
		req_if.request_size  <= sz;
		req_if.return_handle <= hd;
		do @(posedge clk); while (!req_if.ready);
		predicted = best_fit_apply(op, sz, hd);
		replies_due.insert(replies_due.size(), typed ? typed_reply : predicted);
	endtask

	// Response side: check every reply taken, then pick the next stall.
	initial begin
		int stall_left;
		reply_t want;
		stall_left = 0;
		rsp_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_if.valid && rsp_if.ready) begin
				if (replies_due.size() == 0) begin
					failures++;
					if (failures <= 10)
						$display("unexpected reply: status=%0d handle=%h size=%h",
							rsp_if.status, rsp_if.given_handle, rsp_if.given_size);
				end else begin
					want = replies_due.pop_front();
					if (rsp_if.status !== want.status || rsp_if.given_handle !== want.handle ||
							rsp_if.given_size !== want.size) begin
						failures++;
						if (failures <= 10)
							$display("mismatch: want %0d/%h/%h got %0d/%h/%h",
								want.status, want.handle, want.size, rsp_if.status,
								rsp_if.given_handle, rsp_if.given_size);
					end
				end
			end
			if (stall_left > 0) begin
				rsp_if.ready <= 1'b0;
				stall_left--;
			end else begin
				rsp_if.ready <= 1'b1;
				stall_left = idle_span();
			end
		end
	end

	initial begin
		int ret_pct;
		logic op;
		failures = 0;
		cycles = 0;
		pool_fill = 0;
		quiet = 1'b0;
		arst_n = 1'b0;
		req_if.valid = 1'b0;
		req_if.opcode = OP_RETURN;
		req_if.request_size = '0;
		req_if.return_handle = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (DIRECTED[i])
			push_request(DIRECTED[i].op, DIRECTED[i].size, DIRECTED[i].handle,
				DIRECTED[i].typed, DIRECTED[i].reply);

		ret_pct = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// new phase: shift the return/acquire mix so the pool swings full and empty
			if (n % PHASE_LEN == 0) begin
				ret_pct = $urandom_range(20, 80);
				quiet = ($urandom_range(0, 4) == 0);
			end
			op = ($urandom_range(0, 99) < ret_pct) ? OP_RETURN : OP_ACQUIRE;
			push_request(op, pick_size(), HANDLE_W'($urandom_range(0, 65535)), 1'b0, NO_REPLY);
		end
		req_if.valid <= 1'b0;
		quiet = 1'b0;

		while (replies_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/bfbp_pkg.sv
hw/rtl/bfbp_req_if.sv
hw/rtl/bfbp_rsp_if.sv
hw/rtl/bfbp_ram.sv
hw/rtl/bfbp_ctrl.sv
hw/rtl/bfbp_dp.sv
hw/rtl/best_fit_buffer_pool.sv
tb/sv/best_fit_buffer_pool_tb.sv
